>>> hdl/rrl_pkg.sv
// shared constants and types for the rational reduce and limit block
`default_nettype none
package rrl_pkg;
    localparam int TERM_WIDTH = 31;
    localparam int PROD_WIDTH = 2 * TERM_WIDTH;
    localparam int DATA_WIDTH = ((PROD_WIDTH + 7) / 8) * 8;
    localparam int CNT_WIDTH  = $clog2(PROD_WIDTH + 1);
    localparam logic [TERM_WIDTH-1:0] LIMIT_RESET = TERM_WIDTH'(65535);

    typedef struct packed {
        logic start;
        logic wide;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> hdl/rational_reduce_and_limit.sv
// top level: reduces a fraction by its gcd and bounds its terms by a limit
//
// usage:
// - input stream s_axis: tdata holds num_in (bits 30:0) and den_in (bits 61:31)
// - output stream m_axis: tdata holds out_num (bits 30:0) and out_den (61:31)
// - cfg: ratio_limit is written whenever i_cfg_we is high; write it only while idle, the block does not enforce this
// - one transaction in gives exactly one transaction out
// - sequence: the euclid remainder steps, the two reductions and the
//   scaling division all run one after another on the shared 31-bit
//   serial divider; the scaling step first forms a product, then divides
//   it as a 62-bit dividend
// - throughput: one transaction at a time; tready is high only while the
//   sequencer is idle
// - a finished result sits in the output register; if the receiver stalls,
//   the next transaction is still taken and worked on, and waits at the end
//   until the output register frees
// - reset: sequencer idle, output empty, ratio_limit back to 65535
`default_nettype none
module rational_reduce_and_limit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire  [rrl_pkg::DATA_WIDTH-1:0]       i_s_axis_tdata,  // num_in, den_in, zero pad
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    output logic [rrl_pkg::DATA_WIDTH-1:0]       o_m_axis_tdata,  // out_num, out_den, zero pad
    input  wire                                  i_cfg_we,
    input  wire  [rrl_pkg::TERM_WIDTH-1:0]       i_cfg_wdata
);
    localparam int W = rrl_pkg::TERM_WIDTH;
    localparam int P = rrl_pkg::PROD_WIDTH;
    localparam int D = rrl_pkg::DATA_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_GCD, S_GCD_WAIT, S_RN_GO, S_RN_WAIT, S_RD_GO, S_RD_WAIT,
        S_LIMIT, S_MUL, S_SC_GO, S_SC_WAIT, S_FIN
    } t_state;

    t_state       r_state;
    logic [W-1:0] r_lim;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [W-1:0] r_big;
    logic [W-1:0] r_small;
    logic         r_swap;
    logic [P-1:0] r_prod;
    logic         r_out_valid;
    logic [W-1:0] r_out_num;
    logic [W-1:0] r_out_den;

    rrl_pkg::t_div_req div_req;
    rrl_pkg::t_div_rsp div_rsp;
    logic [P-1:0]      div_dividend;
    logic [W-1:0]      div_divisor;
    logic [W-1:0]      div_quo;
    logic [W-1:0]      div_rem;
    logic              in_acc;
    logic              out_free;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        div_req.start = 1'b0;
        div_req.wide  = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;
        unique case (r_state)
            S_GCD: begin
                div_req.start = (r_b != '0);
                div_dividend  = {{(P-W){1'b0}}, r_a};
                div_divisor   = r_b;
            end
            S_RN_GO: begin
                div_req.start = 1'b1;
                div_dividend  = {{(P-W){1'b0}}, r_num};
                div_divisor   = r_a;
            end
            S_RD_GO: begin
                div_req.start = 1'b1;
                div_dividend  = {{(P-W){1'b0}}, r_den};
                div_divisor   = r_a;
            end
            S_SC_GO: begin
                div_req.start = 1'b1;
                div_req.wide  = 1'b1;
                div_dividend  = r_prod;
                div_divisor   = r_big;
            end
            default: begin
            end
        endcase
    end

    rrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_rsp      (div_rsp),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= rrl_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_num   <= i_s_axis_tdata[W-1:0];
                        r_den   <= i_s_axis_tdata[2*W-1:W];
                        r_a     <= i_s_axis_tdata[W-1:0];
                        r_b     <= i_s_axis_tdata[2*W-1:W];
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_b != '0) begin
                        r_state <= S_GCD_WAIT;
                    end else if (r_a != '0) begin
                        r_state <= S_RN_GO;
                    end else begin
                        r_state <= S_LIMIT;
                    end
                end
                S_GCD_WAIT: begin
                    if (div_rsp.done) begin
                        r_a     <= r_b;
                        r_b     <= div_rem;
                        r_state <= S_GCD;
                    end
                end
                S_RN_GO: r_state <= S_RN_WAIT;
                S_RN_WAIT: begin
                    if (div_rsp.done) begin
                        r_num   <= div_quo;
                        r_state <= S_RD_GO;
                    end
                end
                S_RD_GO: r_state <= S_RD_WAIT;
                S_RD_WAIT: begin
                    if (div_rsp.done) begin
                        r_den   <= div_quo;
                        r_state <= S_LIMIT;
                    end
                end
                S_LIMIT: begin
                    r_swap  <= (r_num > r_den);
                    r_big   <= (r_num > r_den) ? r_num : r_den;
                    r_small <= (r_num > r_den) ? r_den : r_num;
                    if (r_num < r_lim && r_den < r_lim) begin
                        r_state <= S_FIN;
                    end else if (r_num == '0 && r_den == '0) begin
                        r_den   <= r_lim;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= {{(P-W){1'b0}}, r_small} * {{(P-W){1'b0}}, r_lim};
                    r_state <= S_SC_GO;
                end
                S_SC_GO: r_state <= S_SC_WAIT;
                S_SC_WAIT: begin
                    if (div_rsp.done) begin
                        r_num   <= r_swap ? r_lim : div_quo;
                        r_den   <= r_swap ? div_quo : r_lim;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_num   <= r_num;
                        r_out_den   <= r_den;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(D-2*W){1'b0}}, r_out_den, r_out_num};

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_GCD))
        else $error("accepted transaction did not start the gcd");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not placed in output register");

    a_scale_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_WAIT && div_rsp.done) |-> (div_quo <= r_lim))
        else $error("scaled term above limit");

    a_wait_has_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_GO || r_state == S_RN_GO || r_state == S_RD_GO)
            |=> div_rsp.busy)
        else $error("divider not running after start");
`endif
endmodule
`default_nettype wire

>>> hdl/rrl_div.sv
// bit-serial restoring divider shared by the gcd, reduction and scaling steps
`default_nettype none
module rrl_div (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  rrl_pkg::t_div_req                    i_req,
    input  wire  [rrl_pkg::PROD_WIDTH-1:0]       i_dividend,
    input  wire  [rrl_pkg::TERM_WIDTH-1:0]       i_divisor,
    output rrl_pkg::t_div_rsp                    o_rsp,
    output logic [rrl_pkg::TERM_WIDTH-1:0]       o_quo,
    output logic [rrl_pkg::TERM_WIDTH-1:0]       o_rem
);
    localparam int W = rrl_pkg::TERM_WIDTH;
    localparam int P = rrl_pkg::PROD_WIDTH;
    localparam int C = rrl_pkg::CNT_WIDTH;

    logic [P-1:0] r_quo;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_dvs;
    logic [C-1:0] r_cnt;
    logic         r_busy;
    logic         r_done;

    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[P-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? diff[W-1:0] : rem_sh[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == C'(1));
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.wide ? C'(P) : C'(W);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_req.wide ? i_dividend : {i_dividend[W-1:0], {(P-W){1'b0}}};
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[P-2:0], ge};
                r_cnt <= r_cnt - C'(1);
                if (r_cnt == C'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quo      = r_quo[W-1:0];
    assign o_rem      = r_rem;
endmodule
`default_nettype wire

>>> test/ratio_checker.sv
// checker that predicts reduced and limited ratios and compares them with the block's output
module ratio_checker
    import rrl_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_tvalid,
    input  wire                  i_in_tready,
    input  wire [DATA_WIDTH-1:0] i_in_tdata,   // num_in, den_in, zero pad
    input  wire                  i_out_tvalid,
    input  wire                  i_out_tready,
    input  wire [DATA_WIDTH-1:0] i_out_tdata,  // out_num, out_den, zero pad
    input  wire                  i_cfg_we,
    input  wire [TERM_WIDTH-1:0] i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_count
);

    typedef struct packed {
        logic [TERM_WIDTH-1:0] den;
        logic [TERM_WIDTH-1:0] num;
    } t_ratio;

    t_ratio                expected_ratios[$];
    logic [TERM_WIDTH-1:0] ratio_limit = LIMIT_RESET;
    int                    mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // gcd reduction, then, unless both terms are below the limit, scale so the larger term equals the limit
    function automatic t_ratio reduce_and_limit(input logic [TERM_WIDTH-1:0] num_in,
                                                input logic [TERM_WIDTH-1:0] den_in,
                                                input logic [TERM_WIDTH-1:0] lim);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] lim_w;
        t_ratio      r;
        a = 64'(num_in);
        b = 64'(den_in);
        while (b != 0) begin
            rem = a % b;
            a = b;
            b = rem;
        end
        num = 64'(num_in);
        den = 64'(den_in);
        lim_w = 64'(lim);
        if (a != 0) begin
            num = num / a;
            den = den / a;
        end
        if (!(num < lim_w && den < lim_w)) begin
            if (num > den) begin
                den = den * lim_w / num;
                num = lim_w;
            end else begin
                num = (den == 0) ? 64'd0 : num * lim_w / den;
                den = lim_w;
            end
        end
        r.num = num[TERM_WIDTH-1:0];
        r.den = den[TERM_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_ratio got;
        t_ratio want;
        if (!i_rst_n) begin
            expected_ratios.delete();
            ratio_limit = LIMIT_RESET;
            o_pending <= 0;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got = i_out_tdata[2*TERM_WIDTH-1:0];
                if (expected_ratios.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction num %0d den %0d",
                                              got.num, got.den));
                end else begin
                    want = expected_ratios.pop_front();
                    if (got.num !== want.num) begin
                        report_mismatch($sformatf("out_num expected %0d got %0d",
                                                  want.num, got.num));
                    end
                    if (got.den !== want.den) begin
                        report_mismatch($sformatf("out_den expected %0d got %0d",
                                                  want.den, got.den));
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                expected_ratios.push_back(reduce_and_limit(
                    i_in_tdata[TERM_WIDTH-1:0],
                    i_in_tdata[2*TERM_WIDTH-1:TERM_WIDTH],
                    ratio_limit));
            end
            if (i_cfg_we) begin
                ratio_limit = i_cfg_wdata;
            end
            o_pending <= expected_ratios.size();
        end
    end

endmodule

>>> test/tb_top.sv
// testbench top: drives ratios and limit settings into the block and gives the verdict
module tb_top;
    import rrl_pkg::*;

    localparam logic [TERM_WIDTH-1:0] TERM_MAX = '1;
    localparam int HOLD_CYCLES   = 5000;
    localparam int SETTLE_CYCLES = 1700;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_WIDTH-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_WIDTH-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [TERM_WIDTH-1:0] cfg_wdata = '0;
    logic [TERM_WIDTH-1:0] cur_limit = LIMIT_RESET;
    logic                  idling_on = 1'b1;
    logic                  hold_request = 1'b0;
    int                    pending;
    int                    fail_count;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rational_reduce_and_limit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    ratio_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // receiver: random stalls while idling is on, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !idling_on || ($urandom_range(99) >= 15);
        end
    end

    task automatic send_ratio(input logic [TERM_WIDTH-1:0] num,
                              input logic [TERM_WIDTH-1:0] den);
        if (idling_on && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= DATA_WIDTH'({den, num});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_random_ratios(input int count, input int hold_at);
        logic [TERM_WIDTH-1:0] n;
        logic [TERM_WIDTH-1:0] d;
        logic [TERM_WIDTH-1:0] g;
        longint                near;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_request = 1'b1;
            end
            case ($urandom_range(5))
                0: begin
                    n = TERM_WIDTH'($urandom());
                    d = TERM_WIDTH'($urandom());
                end
                1: begin
                    n = TERM_WIDTH'($urandom_range(0, 300));
                    d = TERM_WIDTH'($urandom_range(0, 300));
                end
                2: begin
                    // large common factor
                    g = TERM_WIDTH'($urandom_range(1, 65535));
                    n = TERM_WIDTH'(g * $urandom_range(0, 32767));
                    d = TERM_WIDTH'(g * $urandom_range(0, 32767));
                end
                3: begin
                    // one term right around the limit
                    near = longint'(cur_limit) + longint'($urandom_range(4)) - 2;
                    if (near < 0) near = 0;
                    if (near > longint'(TERM_MAX)) near = longint'(TERM_MAX);
                    n = near[TERM_WIDTH-1:0];
                    d = TERM_WIDTH'($urandom()) >> $urandom_range(30);
                end
                4: begin
                    n = TERM_WIDTH'($urandom()) >> $urandom_range(30);
                    d = n;
                end
                default: begin
                    n = $urandom_range(1) ? TERM_MAX : '0;
                    d = TERM_WIDTH'($urandom()) >> $urandom_range(30);
                end
            endcase
            if ($urandom_range(1)) begin
                {n, d} = {d, n};
            end
            send_ratio(n, d);
        end
    endtask

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_limit(input logic [TERM_WIDTH-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        cur_limit = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limit at its reset value
        send_ratio('0, '0);
        send_ratio('0, 5);
        send_ratio(7, '0);
        send_ratio(1, 1);
        send_ratio(TERM_MAX, TERM_MAX);
        send_ratio(TERM_MAX, 1);
        send_ratio(1, TERM_MAX);
        send_ratio(TERM_MAX, TERM_MAX - 1);
        send_ratio(65535, 65535);
        send_ratio(65534, 65535);
        send_ratio(65535, 65534);
        send_ratio(1920, 1080);
        send_ratio(6, 4);
        send_ratio(1836311903, 1134903170);
        send_ratio(1134903170, 1836311903);
        send_ratio(31'h4000_0000, 3);
        send_ratio('0, TERM_MAX);
        send_ratio(TERM_MAX, '0);
        send_ratio(31'h2AAA_AAAA, 31'h5555_5555);
        send_ratio(31'h5555_5555, 31'h2AAA_AAAA);
        send_random_ratios(90, 30);
        drain_results(4);

        set_limit(1);
        send_ratio('0, '0);
        send_ratio(1, 1);
        send_ratio(2, 3);
        send_ratio(TERM_MAX, 1);
        send_random_ratios(40, -1);
        drain_results(4);

        // quiet stretch with no idling on either side
        idling_on = 1'b0;
        set_limit(TERM_MAX);
        send_ratio(TERM_MAX, TERM_MAX - 1);
        send_ratio(TERM_MAX - 1, TERM_MAX);
        send_ratio(TERM_MAX, TERM_MAX);
        send_random_ratios(60, -1);
        drain_results(4);
        idling_on = 1'b1;

        set_limit('0);
        send_ratio('0, '0);
        send_ratio(5, 3);
        send_ratio(3, 5);
        send_ratio(4, 4);
        send_random_ratios(35, -1);
        drain_results(4);

        set_limit(TERM_WIDTH'($urandom_range(2, 1000)));
        send_random_ratios(60, -1);
        drain_results(4);

        set_limit(TERM_WIDTH'($urandom_range(1, 32'h7FFF_FFFF)));
        send_random_ratios(60, -1);
        drain_results(SETTLE_CYCLES);

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hdl/rrl_pkg.sv
hdl/rrl_div.sv
hdl/rational_reduce_and_limit.sv
test/ratio_checker.sv
test/tb_top.sv
